@@ sv/spe_pkg.sv @@
package spe_pkg;

  localparam int NODE_COUNT_DEF = 16;
  localparam int COST_BITS_DEF  = 8;
  localparam int MAX_RESULTS    = 16;
  localparam int DIST_BITS      = 12;
  localparam int NODE_FLD_BITS  = 4;
  localparam int COST_FLD_BITS  = 8;
  localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

  // command codes carried on in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

endpackage

@@ sv/spe_ram.sv @@
module spe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ sv/shortest_path_engine.sv @@
// edge write: S_EW1 and S_EW2 store the cost in both directions of the cost memory
// solve: alternating selection scans and relax passes settle nodes, a parent walk stacks the path,
// then the path nodes are sent from start to end, each held while the output stalls
// throughput: one item at a time, set by the one-entry-per-cycle selection scans and relax passes
// reset: synchronous active low; afterwards a clearing pass over all NODE_COUNT*NODE_COUNT
// entries zeroes the cost memory while in_tready stays low
module shortest_path_engine
  import spe_pkg::*;
#(
  parameter int NODE_COUNT = NODE_COUNT_DEF,
  parameter int COST_BITS  = COST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // first_node[3:0], second_node[7:4], edge_cost[15:8]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // path_node[3:0], total_distance[15:4]
  output logic        out_tuser,  // found
  output logic        out_tlast   // last
);

  localparam int NW = $clog2(NODE_COUNT);
  localparam int EDEPTH = NODE_COUNT * NODE_COUNT;
  localparam int AW = $clog2(EDEPTH);
  localparam int SW = 17;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_EW1, S_EW2, S_INIT, S_SCAN, S_RELAX,
    S_WRD, S_WST, S_ORD, S_OGET, S_OSHOW
  } state_t;

  state_t state_r;

  // sweep counter for the clearing pass
  logic [AW:0]            clr_cnt_r;
  // latched command operands
  logic [NW-1:0]          a_r, b_r;
  logic [COST_BITS-1:0]   cost_r;
  // node flags, one bit per node
  logic [NODE_COUNT-1:0]  reached_r, settled_r;
  // scan / relax pipeline: issue counter and compare stage
  logic [NW:0]            cnt_r;
  logic                   pv_r;
  logic [NW-1:0]          pidx_r;
  // current best candidate of a selection scan, then the node being relaxed
  logic                   best_vld_r;
  logic [NW-1:0]          best_r;
  logic [DIST_BITS-1:0]   best_dist_r;
  // parent walk and output
  logic [NW-1:0]          cur_r;
  logic [NW:0]            len_r;
  logic [NW-1:0]          ok_r;
  logic [DIST_BITS-1:0]   total_r;

  logic                   out_vld_r;
  logic [NODE_FLD_BITS-1:0] out_node_r;
  logic [DIST_BITS-1:0]   out_dist_r;
  logic                   out_found_r, out_last_r;

  // memory ports
  logic                   e_we;
  logic [AW-1:0]          e_waddr, e_raddr;
  logic [COST_BITS-1:0]   e_wdata, e_rdata;
  logic                   d_we;
  logic [NW-1:0]          d_waddr, d_raddr;
  logic [DIST_BITS-1:0]   d_wdata, d_rdata;
  logic [NW-1:0]          p_wdata, p_rdata;
  logic [NW-1:0]          q_rdata;

  logic                   in_xfer, out_xfer;
  logic [NODE_FLD_BITS-1:0] in_a, in_b;
  logic                   a_ok, b_ok;
  logic [SW-1:0]          sum;
  logic [DIST_BITS-1:0]   d_sat;
  logic                   relax_hit, scan_cand;
  logic                   issuing;

  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign out_xfer   = out_vld_r && out_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_dist_r, out_node_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

  assign in_a = in_tdata[3:0];
  assign in_b = in_tdata[7:4];
  assign a_ok = 7'(in_a) < 7'(NODE_COUNT);
  assign b_ok = 7'(in_b) < 7'(NODE_COUNT);

  assign issuing = (cnt_r != (NW+1)'(NODE_COUNT));

  // saturating path sum through the node being relaxed
  assign sum   = SW'(best_dist_r) + SW'(e_rdata);
  assign d_sat = (sum > SW'(DIST_MAX)) ? DIST_MAX : sum[DIST_BITS-1:0];

  assign relax_hit = (state_r == S_RELAX) && pv_r && (e_rdata != '0) && !settled_r[pidx_r]
                     && (!reached_r[pidx_r] || d_sat < d_rdata);
  assign scan_cand = (state_r == S_SCAN) && pv_r && reached_r[pidx_r] && !settled_r[pidx_r]
                     && (!best_vld_r || d_rdata < best_dist_r);

  always_comb begin
    e_we    = (state_r == S_CLEAR) || (state_r == S_EW1) || (state_r == S_EW2);
    e_wdata = (state_r == S_CLEAR) ? '0 : cost_r;
    unique case (state_r)
      S_CLEAR: e_waddr = clr_cnt_r[AW-1:0];
      S_EW1:   e_waddr = AW'(a_r) * AW'(NODE_COUNT) + AW'(b_r);
      default: e_waddr = AW'(b_r) * AW'(NODE_COUNT) + AW'(a_r);
    endcase
    e_raddr = AW'(best_r) * AW'(NODE_COUNT) + AW'(cnt_r[NW-1:0]);

    d_we    = (state_r == S_INIT) || relax_hit;
    d_waddr = (state_r == S_INIT) ? a_r : pidx_r;
    d_wdata = (state_r == S_INIT) ? '0 : d_sat;
    p_wdata = (state_r == S_INIT) ? a_r : best_r;
    d_raddr = (state_r == S_SCAN || state_r == S_RELAX) ? cnt_r[NW-1:0] : cur_r;
  end

  spe_ram #(.WIDTH(COST_BITS), .DEPTH(EDEPTH)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata)
  );

  spe_ram #(.WIDTH(DIST_BITS), .DEPTH(NODE_COUNT)) u_dist_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(d_wdata),
    .raddr(d_raddr), .rdata(d_rdata)
  );

  spe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_parent_ram (
    .clk(clk), .we(d_we), .waddr(d_waddr), .wdata(p_wdata),
    .raddr(cur_r), .rdata(p_rdata)
  );

  // path stack, filled from the end node back to the start
  spe_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT)) u_path_ram (
    .clk(clk), .we(state_r == S_WST), .waddr(len_r[NW-1:0]), .wdata(cur_r),
    .raddr(ok_r), .rdata(q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      out_vld_r  <= 1'b0;
      reached_r  <= '0;
      settled_r  <= '0;
      pv_r       <= 1'b0;
      cnt_r      <= '0;
      best_vld_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == (AW+1)'(EDEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_xfer) begin
            a_r    <= NW'(in_a);
            b_r    <= NW'(in_b);
            cost_r <= COST_BITS'(in_tdata[15:8]);
            if (in_tuser == CMD_WRITE) begin
              if (a_ok && b_ok) state_r <= S_EW1;
            end else if (!a_ok || !b_ok || in_a == in_b) begin
              out_vld_r   <= 1'b1;
              out_node_r  <= '0;
              out_dist_r  <= '0;
              out_found_r <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= S_OSHOW;
            end else begin
              state_r <= S_INIT;
            end
          end
        end
        S_EW1: state_r <= S_EW2;
        S_EW2: state_r <= S_IDLE;
        S_INIT: begin
          // only the start node is reached
          reached_r        <= NODE_COUNT'(1) << a_r;
          settled_r        <= '0;
          cnt_r            <= '0;
          pv_r             <= 1'b0;
          best_vld_r       <= 1'b0;
          state_r          <= S_SCAN;
        end
        S_SCAN: begin
          if (issuing) begin
            pv_r   <= 1'b1;
            pidx_r <= cnt_r[NW-1:0];
            cnt_r  <= cnt_r + 1'b1;
          end else begin
            pv_r <= 1'b0;
          end
          if (scan_cand) begin
            best_vld_r  <= 1'b1;
            best_r      <= pidx_r;
            best_dist_r <= d_rdata;
          end
          if (!issuing && !pv_r) begin
            cnt_r <= '0;
            if (best_vld_r) begin
              settled_r[best_r] <= 1'b1;
              state_r           <= S_RELAX;
            end else if (reached_r[b_r]) begin
              cur_r   <= b_r;
              len_r   <= '0;
              state_r <= S_WRD;
            end else begin
              out_vld_r   <= 1'b1;
              out_node_r  <= '0;
              out_dist_r  <= '0;
              out_found_r <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= S_OSHOW;
            end
          end
        end
        S_RELAX: begin
          if (issuing) begin
            pv_r   <= 1'b1;
            pidx_r <= cnt_r[NW-1:0];
            cnt_r  <= cnt_r + 1'b1;
          end else begin
            pv_r <= 1'b0;
          end
          if (relax_hit) reached_r[pidx_r] <= 1'b1;
          if (!issuing && !pv_r) begin
            cnt_r      <= '0;
            best_vld_r <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_WRD: state_r <= S_WST;
        S_WST: begin
          if (len_r == '0) total_r <= d_rdata;
          len_r <= len_r + 1'b1;
          if (cur_r == a_r) begin
            if (32'(len_r) + 32'd1 > 32'(MAX_RESULTS)) begin
              out_vld_r   <= 1'b1;
              out_node_r  <= '0;
              out_dist_r  <= '0;
              out_found_r <= 1'b0;
              out_last_r  <= 1'b1;
              state_r     <= S_OSHOW;
            end else begin
              ok_r    <= len_r[NW-1:0];
              state_r <= S_ORD;
            end
          end else if (len_r + 1'b1 == (NW+1)'(NODE_COUNT)) begin
            // walk ran out of nodes without meeting the start
            out_vld_r   <= 1'b1;
            out_node_r  <= '0;
            out_dist_r  <= '0;
            out_found_r <= 1'b0;
            out_last_r  <= 1'b1;
            state_r     <= S_OSHOW;
          end else begin
            cur_r   <= p_rdata;
            state_r <= S_WRD;
          end
        end
        // path stack read address settles here, data arrives next cycle
        S_ORD: state_r <= S_OGET;
        S_OGET: begin
          state_r <= S_OSHOW;
          out_vld_r   <= 1'b1;
          out_node_r  <= NODE_FLD_BITS'(q_rdata);
          out_dist_r  <= total_r;
          out_found_r <= 1'b1;
          out_last_r  <= (ok_r == '0);
        end
        S_OSHOW: begin
          if (out_xfer) begin
            out_vld_r <= 1'b0;
            if (out_last_r) begin
              state_r <= S_IDLE;
            end else begin
              ok_r    <= ok_r - 1'b1;
              state_r <= S_ORD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ sv/spe_checker.sv @@
module spe_checker
  import spe_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a solve transfer is followed by a busy cycle
  a_solve_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == CMD_SOLVE |=> !in_tready)
    else $error("input ready right after solve");

  // not-found is a single final all-zero result
  a_nf_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast && out_tdata == '0)
    else $error("malformed not-found result");

  // no input taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready during output");

endmodule

bind shortest_path_engine spe_checker u_spe_checker (.*);

@@ verif/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import spe_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct packed {
    logic [3:0]  node;
    logic [11:0] total;
    logic        found;
    logic        last;
  } path_step_t;

  // graph model and expected path transfers
  class path_scoreboard;
    logic [7:0]  costs [NODES][NODES];
    logic [11:0] node_dist [NODES];
    logic [3:0]  parent [NODES];
    bit          reached [NODES];
    bit          settled [NODES];
    path_step_t  pending[$];
    int          mismatches;

    function void clear_graph();
      foreach (costs[i, j]) costs[i][j] = '0;
      mismatches = 0;
    endfunction

    function void push_not_found();
      path_step_t s;
      s.node = '0;
      s.total = '0;
      s.found = 1'b0;
      s.last = 1'b1;
      pending = {pending, s};
    endfunction

    // dijkstra with lowest index winning ties, saturating sums
    function void shortest_tree(int src);
      int best;
      int d;
      foreach (reached[i]) begin
        reached[i] = 0;
        settled[i] = 0;
      end
      node_dist[src] = '0;
      parent[src] = src[3:0];
      reached[src] = 1;
      for (int r = 0; r < NODES; r++) begin
        best = -1;
        for (int i = 0; i < NODES; i++)
          if (reached[i] && !settled[i] && (best < 0 || node_dist[i] < node_dist[best]))
            best = i;
        if (best < 0) break;
        settled[best] = 1;
        for (int i = 0; i < NODES; i++) begin
          if (costs[best][i] == 0 || settled[i]) continue;
          d = node_dist[best] + costs[best][i];
          if (d > DIST_MAX) d = DIST_MAX;
          if (!reached[i] || d < node_dist[i]) begin
            reached[i] = 1;
            node_dist[i] = d[11:0];
            parent[i] = best[3:0];
          end
        end
      end
    endfunction

    function void note_command(logic cmd, logic [3:0] a, logic [3:0] b, logic [7:0] c);
      int trail[$];
      int cur;
      path_step_t s;
      if (cmd == CMD_WRITE) begin
        costs[a][b] = c;
        costs[b][a] = c;
        return;
      end
      if (a == b) begin
        push_not_found();
        return;
      end
      shortest_tree(a);
      if (!reached[b]) begin
        push_not_found();
        return;
      end
      cur = b;
      while (trail.size() < NODES) begin
        trail.push_front(cur);
        if (cur == a) break;
        cur = parent[cur];
      end
      if (trail[0] != a) begin
        push_not_found();
        return;
      end
      foreach (trail[k]) begin
        s.node = trail[k][3:0];
        s.total = node_dist[b];
        s.found = 1'b1;
        s.last = (k == trail.size() - 1);
        pending = {pending, s};
      end
    endfunction

    function void check_step(path_step_t got);
      path_step_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer node=%0d dist=%0d found=%0b last=%0b",
                                       got.node, got.total, got.found, got.last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: want node=%0d dist=%0d found=%0b last=%0b, got %0d %0d %0b %0b",
                   want.node, want.total, want.found, want.last,
                   got.node, got.total, got.found, got.last);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  path_scoreboard board;
  int send_idle_pct = 0;
  int stall_pct = 0;
  longint cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  shortest_path_engine uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata),   // first_node, second_node, edge_cost
    .in_tuser(in_tuser),   // command
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), // path_node, total_distance
    .out_tuser(out_tuser), // found
    .out_tlast(out_tlast)  // last
  );

  // receiver: check every output transfer, random backpressure
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_step({out_tdata[3:0], out_tdata[15:4], out_tuser, out_tlast});
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // run guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // one input transfer; the model notes it at the accepting edge
  // tvalid drops only while the sender idles, or after the last item
  task automatic send(logic cmd, logic [3:0] a, logic [3:0] b, logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {c, b, a};
    do @(posedge clk); while (!in_tready);
    board.note_command(cmd, a, b, c);
    @(negedge clk);
  endtask

  task automatic random_item();
    int pick;
    logic [7:0] c;
    pick = $urandom_range(99);
    c = ($urandom_range(4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 20));
    if ($urandom_range(9) == 0) c = 8'd0;
    if (pick < 60)
      send(CMD_WRITE, 4'($urandom), 4'($urandom), c);
    else
      send(CMD_SOLVE, 4'($urandom), 4'($urandom), 8'($urandom));
  endtask

  initial begin
    int phase;
    board = new();
    board.clear_graph();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty graph, equal ends, chain, heavy edges, removal
    send(CMD_SOLVE, 4'd0, 4'd15, 8'hff);
    send(CMD_SOLVE, 4'd3, 4'd3, 8'h00);
    send(CMD_WRITE, 4'd5, 4'd5, 8'd7);
    send(CMD_SOLVE, 4'd5, 4'd5, 8'd0);
    for (int i = 0; i < 15; i++) send(CMD_WRITE, i[3:0], i[3:0] + 4'd1, 8'hff);
    send(CMD_SOLVE, 4'd0, 4'd15, 8'd0);
    send(CMD_SOLVE, 4'd15, 4'd0, 8'd0);
    send(CMD_WRITE, 4'd0, 4'd2, 8'd1);
    send(CMD_WRITE, 4'd2, 4'd3, 8'd255);
    send(CMD_SOLVE, 4'd0, 4'd3, 8'd0);
    send(CMD_WRITE, 4'd7, 4'd8, 8'd0);
    send(CMD_SOLVE, 4'd0, 4'd9, 8'd0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 71; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 71; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      // random writes and solves on the running graph
      for (int i = 0; i < 70; i++) random_item();
    end
    in_tvalid <= 1'b0;

    send_idle_pct = 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
